// File: hw/rtl/dda_pkg.sv
// Package for the DDA line raster canvas: request codes, queue entry type and helpers.
// Depends on nothing; used by dda_front, dda_back, the top level and the testbench.
package dda_pkg;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_POINT = 2'd1,
        MODE_LINE  = 2'd2,
        MODE_READ  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [3:0]         row_select;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_PLOT,
        BK_CLEAR,
        BK_DONE
    } bk_state_t;

    localparam logic [6:0] WIDTH_RESET  = 7'd60;
    localparam logic [4:0] HEIGHT_RESET = 5'd15;
    localparam logic       CFG_WIDTH    = 1'b0;
    localparam logic       CFG_HEIGHT   = 1'b1;

    // Rounds a signed Q.16 value to an integer, half away from zero.
    function automatic logic signed [24:0] round_q16(input logic signed [40:0] v);
        logic [40:0] mag;
        logic [40:0] r;
        begin
            mag = v[40] ? 41'(-v) : 41'(v);
            r = (mag + 41'h8000) >> 16;
            round_q16 = v[40] ? -25'(r) : 25'(r);
        end
    endfunction

endpackage

// File: hw/rtl/dda_front.sv
// Front part: accepts requests and holds them in a two-entry queue.
// Depends on dda_pkg.
module dda_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  dda_pkg::req_t req,
    output logic          busy,
    output logic          q_valid,
    output dda_pkg::req_t q_req,
    input  logic          q_pop
);
    import dda_pkg::*;

    req_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule

// File: hw/rtl/dda_div.sv
// Restoring divider for the line steps: rounds |d| * 65536 / dmax half away from zero.
// Depends on nothing.
module dda_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [16:0] num,
    input  logic [16:0] den,
    output logic        ready,
    output logic [17:0] quot
);
    // Computes floor((num * 131072 + den) / (2 * den)).
    logic [34:0] rem_reg, rem_next;
    logic [34:0] dvd_reg;
    logic [34:0] q_reg;
    logic [17:0] den2_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic [35:0] trial;

    assign trial = {rem_reg, dvd_reg[34]} - {18'd0, den2_reg};
    assign rem_next = trial[35] ? {rem_reg[33:0], dvd_reg[34]} : trial[34:0];
    assign ready = !run_reg;
    assign quot  = q_reg[17:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= 6'd0;
        end
        else if (go)
        begin
            run_reg <= 1'b1;
            cnt_reg <= 6'd35;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg  <= 35'd0;
            dvd_reg  <= {1'b0, num, 17'd0} + {18'd0, den};
            den2_reg <= {den, 1'b0};
            q_reg    <= 35'd0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[33:0], 1'b0};
            q_reg   <= {q_reg[33:0], !trial[35]};
        end
    end
endmodule

// File: hw/rtl/dda_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
module dda_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: hw/rtl/dda_back.sv
// Back part: clears, plots points and lines, and reads rows of the canvas.
// Depends on dda_pkg, dda_div and dda_ram.
module dda_back #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [6:0]    canvas_width,
    input  logic [4:0]    canvas_height,
    input  logic          q_valid,
    input  dda_pkg::req_t q_req,
    output logic          q_pop,
    output logic          res_valid,
    output logic [63:0]   res_row
);
    import dda_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);

    bk_state_t state_reg, state_next;
    req_t      cur_reg;
    logic signed [40:0] px_reg, py_reg;
    logic signed [18:0] stx_reg, sty_reg;
    logic [8:0]  cnt_reg;
    logic        axis_reg;
    logic [1:0]  ph_reg;
    logic [AW:0] clr_reg;
    logic        init_reg;
    logic [AW-1:0] ptr_reg;
    logic        hit_reg;
    logic [5:0]  col_reg;
    logic        rd_sel_ok;

    logic signed [16:0] dx, dy;
    logic [16:0] adx, ady, dmax;
    logic        div_go, div_ready;
    logic [17:0] quot;
    logic        we;
    logic [AW-1:0] addr;
    logic [63:0] wdata, rdata;
    logic signed [24:0] ix, iy;
    logic [7:0]  w_eff, h_eff;
    logic        hit;
    logic [7:0]  row_calc;

    assign dx   = 17'(cur_reg.end_x) - 17'(cur_reg.start_x);
    assign dy   = 17'(cur_reg.end_y) - 17'(cur_reg.start_y);
    assign adx  = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady  = dy[16] ? 17'(-dy) : 17'(dy);
    assign dmax = (adx > ady) ? adx : ady;

    assign w_eff = (8'(canvas_width) < 8'(MAX_COLUMNS)) ? 8'(canvas_width) : 8'(MAX_COLUMNS);
    assign h_eff = (8'(canvas_height) < 8'(MAX_ROWS)) ? 8'(canvas_height) : 8'(MAX_ROWS);
    assign ix  = round_q16(px_reg);
    assign iy  = round_q16(py_reg);
    assign hit = !ix[24] && !iy[24] && (ix < 25'(w_eff)) && (iy < 25'(h_eff));
    assign row_calc = h_eff - 8'd1 - iy[7:0];
    assign rd_sel_ok = (32'(cur_reg.row_select) < MAX_ROWS);

    assign div_go = (state_reg == BK_DIV) && (ph_reg == 2'd0);

    dda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (axis_reg ? ady : adx),
        .den   (dmax),
        .ready (div_ready),
        .quot  (quot)
    );

    dda_ram #(.WIDTH(64), .DEPTH(MAX_ROWS)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_req.mode)
                        MODE_CLEAR: state_next = BK_CLEAR;
                        MODE_LINE:  state_next = BK_DIV;
                        MODE_POINT: state_next = BK_PLOT;
                        default:    state_next = BK_DONE;
                    endcase
                end
            end
            BK_DIV:
            begin
                if (ph_reg == 2'd3 && div_ready && axis_reg)
                begin
                    state_next = BK_PLOT;
                end
            end
            BK_PLOT:
            begin
                if (ph_reg == 2'd2 && cnt_reg == 9'd0)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_CLEAR:
            begin
                if (clr_reg == (AW+1)'(MAX_ROWS - 1))
                begin
                    state_next = init_reg ? BK_IDLE : BK_DONE;
                end
            end
            BK_DONE:
            begin
                state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = (state_reg == BK_IDLE) && q_valid;
        res_valid = (state_reg == BK_DONE);
        res_row   = (cur_reg.mode == MODE_READ && rd_sel_ok) ? rdata : 64'd0;
        we        = 1'b0;
        addr      = ptr_reg;
        wdata     = rdata | (64'd1 << col_reg);
        case (state_reg)
            BK_IDLE:
            begin
                addr = AW'(q_req.row_select);
            end
            BK_PLOT:
            begin
                we = (ph_reg == 2'd2) && hit_reg;
            end
            BK_CLEAR:
            begin
                we    = 1'b1;
                addr  = clr_reg[AW-1:0];
                wdata = 64'd0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            ph_reg    <= 2'd0;
            axis_reg  <= 1'b0;
            init_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                BK_IDLE:
                begin
                    ph_reg   <= 2'd0;
                    axis_reg <= 1'b0;
                    clr_reg  <= '0;
                    init_reg <= 1'b0;
                end
                BK_DIV:
                begin
                    if (ph_reg == 2'd0)
                    begin
                        ph_reg <= 2'd3;
                    end
                    else if (div_ready)
                    begin
                        axis_reg <= 1'b1;
                        ph_reg   <= axis_reg ? 2'd0 : 2'd0;
                    end
                end
                BK_PLOT:
                begin
                    ph_reg <= (ph_reg == 2'd2) ? 2'd0 : ph_reg + 2'd1;
                end
                BK_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    cur_reg <= q_req;
                    px_reg  <= 41'(q_req.start_x) <<< 8;
                    py_reg  <= 41'(q_req.start_y) <<< 8;
                    stx_reg <= '0;
                    sty_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            BK_DIV:
            begin
                cnt_reg <= dmax[16:8];
                if (ph_reg == 2'd3 && div_ready && dmax != 17'd0)
                begin
                    if (axis_reg)
                    begin
                        sty_reg <= dy[16] ? -19'(quot) : 19'(quot);
                    end
                    else
                    begin
                        stx_reg <= dx[16] ? -19'(quot) : 19'(quot);
                    end
                end
            end
            BK_PLOT:
            begin
                case (ph_reg)
                    2'd0:
                    begin
                        hit_reg <= hit;
                        col_reg <= ix[5:0];
                        ptr_reg <= row_calc[AW-1:0];
                    end
                    2'd2:
                    begin
                        px_reg  <= px_reg + 41'(stx_reg);
                        py_reg  <= py_reg + 41'(sty_reg);
                        cnt_reg <= cnt_reg - 9'd1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end
endmodule

// File: hw/rtl/dda_line_raster_canvas_unit.sv
// Top level of the DDA line raster canvas: registers, front queue and back engine.
// Depends on dda_pkg, dda_front and dda_back.
//
//  channel | signals                                  | direction
//  request | start, busy, mode, start_x..end_y, row_select | in
//  result  | done, row_bits, done_res                 | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A line runs set-up and the two serial divisions, then plots its points one after another.
// Reset runs a clearing pass over all MAX_ROWS rows; the queue takes requests during it.
// busy rises only when the two-entry queue is full; results cannot be stalled.
module dda_line_raster_canvas_unit #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [15:0] start_x,
    input  logic signed [15:0] start_y,
    input  logic signed [15:0] end_x,
    input  logic signed [15:0] end_y,
    input  logic [3:0]         row_select,
    output logic               done,
    output logic [63:0]        row_bits,
    output logic               done_res,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [6:0]         cfg_data
);
    import dda_pkg::*;

    logic [6:0] width_reg;
    logic [4:0] height_reg;
    req_t       req, q_req;
    logic       q_valid, q_pop;

    assign cfg_ready = 1'b1;
    assign done_res  = 1'b1;

    always_comb
    begin
        req.mode       = mode_t'(mode);
        req.start_x    = start_x;
        req.start_y    = start_y;
        req.end_x      = end_x;
        req.end_y      = end_y;
        req.row_select = row_select;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data[4:0];
            end
        end
    end

    dda_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req     (req),
        .busy    (busy),
        .q_valid (q_valid),
        .q_req   (q_req),
        .q_pop   (q_pop)
    );

    dda_back #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .canvas_width  (width_reg),
        .canvas_height (height_reg),
        .q_valid       (q_valid),
        .q_req         (q_req),
        .q_pop         (q_pop),
        .res_valid     (done),
        .res_row       (row_bits)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("queue popped while empty");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result strobe held longer than one cycle");
`endif
endmodule

// File: test/tb_dda_line_raster_canvas_unit.sv
// Self-checking testbench for the DDA line raster canvas unit: clears, points, lines and row
// reads against an in-bench canvas predictor, with bursty requests and register changes.
// Depends on dda_pkg and dda_line_raster_canvas_unit.
module tb_dda_line_raster_canvas_unit;
    import dda_pkg::*;

    localparam int NUM_COLS  = 64;
    localparam int NUM_ROWS  = 16;
    localparam int MAX_CYCLE = 8000000;

    typedef struct {
        logic [63:0] row;
        logic        fin;
    } row_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         mode = '0;
    logic signed [15:0] start_x = '0;
    logic signed [15:0] start_y = '0;
    logic signed [15:0] end_x = '0;
    logic signed [15:0] end_y = '0;
    logic [3:0]         row_select = '0;
    logic               done;
    logic [63:0]        row_bits;
    logic               done_res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_index = 1'b0;
    logic [6:0]         cfg_data = '0;

    req_t        request_queue[$];
    row_word_t   row_words_due[$];
    logic [63:0] canvas[NUM_ROWS];
    int          cols_in_use = 60;
    int          rows_in_use = 15;
    int          burst_left = 0;
    int          gap_left = 0;
    int          errors = 0;
    int          cycle_count = 0;

    dda_line_raster_canvas_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .row_select (row_select),
        .done       (done),
        .row_bits   (row_bits),
        .done_res   (done_res),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic longint round_to_pixel(input longint v);
        if (v >= 0)
            return (v + 32768) >>> 16;
        return -((-v + 32768) >>> 16);
    endfunction

    function automatic void set_pixel(input longint px, input longint py);
        longint w;
        longint h;
        longint ix;
        longint iy;
        w = (cols_in_use < NUM_COLS) ? cols_in_use : NUM_COLS;
        h = (rows_in_use < NUM_ROWS) ? rows_in_use : NUM_ROWS;
        ix = round_to_pixel(px);
        iy = round_to_pixel(py);
        if (ix < 0 || ix >= w || iy < 0 || iy >= h)
            return;
        canvas[h - 1 - iy][ix] = 1'b1;
    endfunction

    function automatic longint line_step(input longint d, input longint dmax);
        longint mag;
        longint q;
        if (dmax <= 0)
            return 0;
        mag = (d < 0) ? -d : d;
        q = (mag * 131072 + dmax) / (2 * dmax);
        return (d < 0) ? -q : q;
    endfunction

    // Applies one request to the canvas copy and returns the row word it produces.
    function automatic row_word_t apply_request(input req_t r);
        row_word_t res;
        longint    dx;
        longint    dy;
        longint    dmax;
        longint    stx;
        longint    sty;
        longint    px;
        longint    py;
        longint    count;
        res.row = '0;
        res.fin = 1'b1;
        case (r.mode)
            MODE_CLEAR:
                for (int i = 0; i < NUM_ROWS; i++)
                    canvas[i] = '0;
            MODE_POINT:
                set_pixel(longint'(r.start_x) * 256, longint'(r.start_y) * 256);
            MODE_LINE:
            begin
                dx = longint'(r.end_x) - longint'(r.start_x);
                dy = longint'(r.end_y) - longint'(r.start_y);
                dmax = ((dx < 0) ? -dx : dx);
                if (((dy < 0) ? -dy : dy) > dmax)
                    dmax = (dy < 0) ? -dy : dy;
                stx = line_step(dx, dmax);
                sty = line_step(dy, dmax);
                px = longint'(r.start_x) * 256;
                py = longint'(r.start_y) * 256;
                count = dmax / 256 + 1;
                for (longint k = 0; k < count; k++)
                begin
                    set_pixel(px, py);
                    px += stx;
                    py += sty;
                end
            end
            default:
                res.row = canvas[r.row_select];
        endcase
        return res;
    endfunction

    function automatic req_t make_request(input mode_t m, input int sx, input int sy,
                                          input int ex, input int ey, input int sel);
        req_t r;
        r.mode = m;
        r.start_x = 16'(sx);
        r.start_y = 16'(sy);
        r.end_x = 16'(ex);
        r.end_y = 16'(ey);
        r.row_select = 4'(sel);
        return r;
    endfunction

    // Mostly near the visible canvas, with a fraction anywhere in the Q7.8 range.
    function automatic int rand_coord(input int extent);
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(0, 65535)) - 32768;
        return (int'($urandom_range(0, extent + 6)) - 3) * 256 + int'($urandom_range(0, 255))
               - 128;
    endfunction

    function automatic req_t random_request();
        int sel;
        int sx;
        int sy;
        int ex;
        int ey;
        sel = $urandom_range(0, 99);
        sx = rand_coord(cols_in_use > 64 ? 64 : cols_in_use);
        sy = rand_coord(rows_in_use > 16 ? 16 : rows_in_use);
        ex = sx + int'($urandom_range(0, 5120)) - 2560;
        ey = sy + int'($urandom_range(0, 2560)) - 1280;
        if ($urandom_range(0, 39) == 0)
        begin
            ex = int'($urandom_range(0, 65535)) - 32768;
            ey = int'($urandom_range(0, 65535)) - 32768;
        end
        if (ex > 32767)
            ex = 32767;
        if (ex < -32768)
            ex = -32768;
        if (ey > 32767)
            ey = 32767;
        if (ey < -32768)
            ey = -32768;
        if (sel < 3)
            return make_request(MODE_CLEAR, sx, sy, ex, ey, $urandom_range(0, 15));
        if (sel < 30)
            return make_request(MODE_POINT, sx, sy, ex, ey, $urandom_range(0, 15));
        if (sel < 65)
            return make_request(MODE_LINE, sx, sy, ex, ey, $urandom_range(0, 15));
        return make_request(MODE_READ, sx, sy, ex, ey, $urandom_range(0, 15));
    endfunction

    task automatic drain();
        while (request_queue.size() != 0 || row_words_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [6:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_WIDTH)
            cols_in_use = value;
        else
            rows_in_use = value & 7'h1F;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_row_reads();
        for (int i = 0; i < NUM_ROWS; i++)
            request_queue.push_back(make_request(MODE_READ, 0, 0, 0, 0, i));
    endtask

    // Request acceptance and result checking.
    always @(posedge clk)
    begin
        row_word_t got;
        cycle_count <= cycle_count + 1;
        if (start && !busy && rst_n)
        begin
            row_words_due.push_back(apply_request(request_queue.pop_front()));
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
        end
        if (done && rst_n)
        begin
            if (row_words_due.size() == 0)
            begin
                $error("unexpected result: row_bits %h done_res %b", row_bits, done_res);
                errors++;
            end
            else
            begin
                got = row_words_due.pop_front();
                if (row_bits !== got.row)
                begin
                    $error("row_bits mismatch: expected %h actual %h", got.row, row_bits);
                    errors++;
                end
                if (done_res !== got.fin)
                begin
                    $error("done_res mismatch: expected %b actual %b", got.fin, done_res);
                    errors++;
                end
            end
        end
    end

    // Request driver: bursts of requests separated by random gaps.
    always @(negedge clk)
    begin
        if (gap_left > 0)
        begin
            gap_left--;
            start <= 1'b0;
        end
        else if (rst_n && request_queue.size() != 0)
        begin
            start <= 1'b1;
            mode <= request_queue[0].mode;
            start_x <= request_queue[0].start_x;
            start_y <= request_queue[0].start_y;
            end_x <= request_queue[0].end_x;
            end_y <= request_queue[0].end_y;
            row_select <= request_queue[0].row_select;
        end
        else
            start <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (cycle_count > MAX_CYCLE)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int widths[7];
        int heights[7];
        widths = '{60, 64, 1, 127, 0, 8, 33};
        heights = '{15, 16, 1, 31, 5, 0, 9};
        for (int i = 0; i < NUM_ROWS; i++)
            canvas[i] = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        queue_row_reads();
        request_queue.push_back(make_request(MODE_POINT, 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(MODE_POINT, 128, 128, 0, 0, 0));
        request_queue.push_back(make_request(MODE_POINT, -128, 3 * 256, 0, 0, 0));
        request_queue.push_back(make_request(MODE_POINT, 59 * 256, 14 * 256, 0, 0, 0));
        request_queue.push_back(make_request(MODE_POINT, 32767, -32768, 0, 0, 0));
        request_queue.push_back(make_request(MODE_LINE, 512, 512, 512, 512, 0));
        request_queue.push_back(make_request(MODE_LINE, 0, 0, 59 * 256, 14 * 256, 0));
        request_queue.push_back(make_request(MODE_LINE, 10 * 256, 0, 10 * 256, 14 * 256, 0));
        request_queue.push_back(make_request(MODE_LINE, -32768, 32767, 32767, -32768, 0));
        queue_row_reads();
        request_queue.push_back(make_request(MODE_CLEAR, 0, 0, 0, 0, 0));
        request_queue.push_back(make_request(MODE_READ, 0, 0, 0, 0, 14));
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_register(CFG_WIDTH, 7'(widths[ph]));
            write_register(CFG_HEIGHT, 7'(heights[ph]));
            for (int n = 0; n < 250; n++)
                request_queue.push_back(random_request());
            queue_row_reads();
            drain();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dda_pkg.sv
hw/rtl/dda_front.sv
hw/rtl/dda_div.sv
hw/rtl/dda_ram.sv
hw/rtl/dda_back.sv
hw/rtl/dda_line_raster_canvas_unit.sv
test/tb_dda_line_raster_canvas_unit.sv
